FILE: hw/rtl/mmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types, register indexes and constants of the motor mixer.
// ----------------------------------------------------------------------------
package mmm_pkg;

    localparam int CorrW  = 11;
    localparam int MixW   = 14;   // signed mix values, fit |v| < 8192
    localparam int NumW   = 18;   // signed dividend, up to 255*256
    localparam int QuoW   = 17;   // unsigned quotient magnitude
    localparam int DivW   = 13;   // unsigned divisor (swing), below 4096

    typedef enum logic [1:0] {
        FRAME_PLUS  = 2'd0,
        FRAME_CROSS = 2'd1,
        FRAME_P45   = 2'd2,
        FRAME_TRI   = 2'd3
    } frame_t;

    typedef enum logic [1:0] {
        REG_FRAME_MODE    = 2'd0,
        REG_OUT_MAX       = 2'd1,
        REG_LOW_RUN       = 2'd2,
        REG_SERVO_NEUTRAL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        frame_t     mode;
        logic [7:0] out_max;
        logic [7:0] low_run;
        logic [7:0] servo_neutral;
    } cfg_t;

    typedef struct packed {
        logic signed [MixW-1:0] m0;
        logic signed [MixW-1:0] m1;
        logic signed [MixW-1:0] m2;
        logic signed [MixW-1:0] m3;
    } mix_t;

    // Four-way mix for one frame geometry.
    function automatic mix_t mix_f(
        input frame_t                  mode,
        input logic [7:0]              t,
        input logic signed [CorrW-1:0] r,
        input logic signed [CorrW-1:0] p,
        input logic signed [CorrW-1:0] y,
        input logic [7:0]              neutral
    );
        mix_t o;
        logic signed [MixW-1:0] ts, rs, ps, ys, h;
        ts = MixW'($signed({1'b0, t}));
        rs = MixW'(r);
        ps = MixW'(p);
        ys = MixW'(y);
        h  = (rs - ps) >>> 1;  // floor half
        unique case (mode)
            FRAME_PLUS: begin
                o.m0 = ts - ps + ys; o.m1 = ts - rs - ys;
                o.m2 = ts + rs - ys; o.m3 = ts + ps + ys;
            end
            FRAME_CROSS: begin
                o.m0 = ts - ps - rs + ys; o.m1 = ts + ps - rs - ys;
                o.m2 = ts - ps + rs - ys; o.m3 = ts + ps + rs + ys;
            end
            FRAME_P45: begin
                o.m0 = ts + rs - ps + ys; o.m1 = ts - rs - ps - ys;
                o.m2 = ts + rs + ps - ys; o.m3 = ts - rs + ps + ys;
            end
            default: begin
                o.m0 = ts + ps; o.m1 = ts + h; o.m2 = ts - h;
                o.m3 = MixW'($signed({1'b0, neutral})) + ys;
            end
        endcase
        return o;
    endfunction

    function automatic logic [7:0] sat8(input logic signed [MixW-1:0] v);
        logic [7:0] o;
        if (v < 0) o = 8'd0;
        else if (v > 255) o = 8'd255;
        else o = v[7:0];
        return o;
    endfunction

    // (c*s + 128)/256 truncated toward zero, s in 0..255
    function automatic logic signed [CorrW-1:0] scale_corr(
        input logic signed [CorrW-1:0] c,
        input logic [7:0]              s
    );
        logic signed [20:0] prod;
        logic signed [20:0] q;
        prod = 21'(c) * $signed({13'd0, s}) + 21'sd128;
        if (prod < 0) q = -((-prod) >>> 8);
        else q = prod >>> 8;
        return q[CorrW-1:0];
    endfunction

endpackage

FILE: hw/rtl/mmm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_div
// Pipelined restoring divider: a capture stage, then one quotient bit per
// stage. Valid bits travel with the operands. Unsigned magnitudes only.
// ----------------------------------------------------------------------------
module mmm_div
    import mmm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [QuoW-1:0]        num,
    input  logic [DivW-1:0]        den,
    output logic [QuoW-1:0]        quo
);

    logic [QuoW-1:0] rem_reg  [QuoW+1];
    logic [QuoW-1:0] q_reg    [QuoW+1];
    logic [QuoW-1:0] n_reg    [QuoW+1];
    logic [DivW-1:0] d_reg    [QuoW+1];
    logic            v_reg    [QuoW+1];

    // stage 0 captures operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg[0] <= 1'b0;
        else if (adv) v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            n_reg[0]   <= num;
            d_reg[0]   <= den;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < QuoW; i++)
    begin : g_stage
        logic [QuoW:0]   trial;
        logic [QuoW-1:0] rem_sh;
        assign rem_sh = {rem_reg[i][QuoW-2:0], n_reg[i][QuoW-1-i]};
        assign trial  = {1'b0, rem_sh} - {{(QuoW+1-DivW){1'b0}}, d_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[i+1] <= 1'b0;
            else if (adv) v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1] <= trial[QuoW] ? rem_sh : trial[QuoW-1:0];
                q_reg[i+1]   <= {q_reg[i][QuoW-2:0], ~trial[QuoW]};
                n_reg[i+1]   <= n_reg[i];
                d_reg[i+1]   <= d_reg[i];
            end
        end
    end

    assign quo = q_reg[QuoW];

    // the final remainder stays below the divisor, unless the divisor is zero
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QuoW] |-> ({4'd0, rem_reg[QuoW]} < {8'd0, d_reg[QuoW]} + 21'd0
                          || d_reg[QuoW] == '0))
        else $error("divider remainder not below divisor");

endmodule

FILE: hw/rtl/multirotor_motor_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multirotor_motor_mixer
// Four-output motor mixer with headroom rescale of the corrections.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfer: throttle plus signed roll/pitch/yaw corrections on
//   in_valid/in_ready. Output transfer: four saturated commands and a
//   rescaled flag on out_valid/out_ready. Configuration via cfg_we,
//   cfg_index, cfg_wdata while idle.
//   Pipeline: 3 front stages, 18 divider stages (a
//   capture stage and 17 quotient-bit stages) and 2 back stages.
//   Throughput: one item per cycle while not stalled; the two pipelined
//   restoring dividers (one quotient bit per stage) set the depth, not the rate.
//   Reset clears all valid bits and loads the register defaults.
//   When the receiver stalls the whole pipeline holds; in_ready follows
//   out_ready or an empty output slot, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module multirotor_motor_mixer
    import mmm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [7:0]              cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              throttle,
    input  logic signed [CorrW-1:0] roll_corr,
    input  logic signed [CorrW-1:0] pitch_corr,
    input  logic signed [CorrW-1:0] yaw_corr,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              front_cmd,
    output logic [7:0]              left_cmd,
    output logic [7:0]              right_cmd,
    output logic [7:0]              back_cmd,
    output logic                    rescaled
);

    localparam int Lat = QuoW + 1;  // divider delay

    cfg_t cfg_reg;
    logic adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: FRAME_PLUS, out_max: 8'd200, low_run: 8'd20,
                         servo_neutral: 8'd128};
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_MODE:    cfg_reg.mode <= frame_t'(cfg_wdata[1:0]);
                REG_OUT_MAX:       cfg_reg.out_max <= cfg_wdata;
                REG_LOW_RUN:       cfg_reg.low_run <= cfg_wdata;
                REG_SERVO_NEUTRAL: cfg_reg.servo_neutral <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 1: register inputs and limit throttle
    logic                    v1_reg;
    logic [7:0]              t1_reg;
    logic signed [CorrW-1:0] r1_reg, p1_reg, y1_reg;
    logic [15:0]             lim_prod;
    logic [31:0]             lim_mul;
    logic [7:0]              lim;
    assign lim_prod = 16'(cfg_reg.out_max) * 16'd90 + 16'd50;
    // divide by 100 via reciprocal, exact for dividends up to 23000
    assign lim_mul  = 32'(lim_prod) * 32'd41944;
    assign lim      = lim_mul[29:22];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (adv) v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg <= (throttle > lim) ? lim : throttle;
            r1_reg <= roll_corr;
            p1_reg <= pitch_corr;
            y1_reg <= yaw_corr;
        end
    end

    // stage 2: first mix
    logic                    v2_reg;
    logic [7:0]              t2_reg;
    logic signed [CorrW-1:0] r2_reg, p2_reg, y2_reg;
    mix_t                    m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg <= t1_reg;
            r2_reg <= r1_reg;
            p2_reg <= p1_reg;
            y2_reg <= y1_reg;
            m2_reg <= mix_f(cfg_reg.mode, t1_reg, r1_reg, p1_reg, y1_reg,
                            cfg_reg.servo_neutral);
        end
    end

    // stage 3: largest motor, swing and signed numerators
    logic signed [MixW-1:0] mx, swing;
    logic signed [NumW-1:0] hi_num, lo_num;
    always_comb
    begin
        mx = m2_reg.m0;
        if (m2_reg.m1 > mx) mx = m2_reg.m1;
        if (m2_reg.m2 > mx) mx = m2_reg.m2;
        if (cfg_reg.mode != FRAME_TRI && m2_reg.m3 > mx) mx = m2_reg.m3;
        swing  = mx - MixW'($signed({1'b0, t2_reg}));
        hi_num = NumW'($signed({1'b0, cfg_reg.out_max}) - $signed({1'b0, t2_reg}))
                 <<< 8;
        lo_num = NumW'($signed({1'b0, t2_reg}) - $signed({1'b0, cfg_reg.low_run}))
                 <<< 8;
    end

    logic                    v3_reg, sp3_reg, hn3_reg, ln3_reg;
    logic [QuoW-1:0]         hm3_reg, lm3_reg;
    logic [DivW-1:0]         sw3_reg;
    logic [7:0]              t3_reg;
    logic signed [CorrW-1:0] r3_reg, p3_reg, y3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp3_reg <= swing > 0;
            sw3_reg <= (swing > 0) ? DivW'(swing) : DivW'(1);
            hn3_reg <= hi_num < 0;
            ln3_reg <= lo_num < 0;
            hm3_reg <= QuoW'((hi_num < 0) ? -hi_num : hi_num);
            lm3_reg <= QuoW'((lo_num < 0) ? -lo_num : lo_num);
            t3_reg  <= t2_reg;
            r3_reg  <= r2_reg;
            p3_reg  <= p2_reg;
            y3_reg  <= y2_reg;
        end
    end

    // dividers
    logic [QuoW-1:0] hq, lq;
    mmm_div u_div_hi (.clk, .rst_n, .adv, .in_valid(v3_reg),
                      .num(hm3_reg), .den(sw3_reg), .quo(hq));
    mmm_div u_div_lo (.clk, .rst_n, .adv, .in_valid(v3_reg),
                      .num(lm3_reg), .den(sw3_reg), .quo(lq));

    // side delay line matching the dividers
    typedef struct packed {
        logic                    v;
        logic                    sp;
        logic                    hn;
        logic                    ln;
        logic [7:0]              t;
        logic signed [CorrW-1:0] r;
        logic signed [CorrW-1:0] p;
        logic signed [CorrW-1:0] y;
    } side_t;

    side_t sd_reg [Lat];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lat; i++) sd_reg[i] <= '0;
        end
        else if (adv)
        begin
            sd_reg[0] <= '{v: v3_reg, sp: sp3_reg, hn: hn3_reg, ln: ln3_reg,
                           t: t3_reg, r: r3_reg, p: p3_reg, y: y3_reg};
            for (int i = 1; i < Lat; i++) sd_reg[i] <= sd_reg[i-1];
        end
    end

    // stage 4: pick scale, scale corrections
    side_t                  s4;
    logic signed [QuoW:0]   hs, ls, sc;
    logic                   resc;
    assign s4 = sd_reg[Lat-1];
    always_comb
    begin
        hs = s4.hn ? -$signed({1'b0, hq}) : $signed({1'b0, hq});
        ls = s4.ln ? -$signed({1'b0, lq}) : $signed({1'b0, lq});
        sc = (hs < ls) ? hs : ls;
        if (sc < 0) sc = '0;
        resc = s4.sp && (sc < 256);
    end

    logic                    v5_reg, rs5_reg;
    logic [7:0]              t5_reg;
    logic signed [CorrW-1:0] r5_reg, p5_reg, y5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (adv) v5_reg <= s4.v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs5_reg <= resc;
            t5_reg  <= s4.t;
            r5_reg  <= resc ? scale_corr(s4.r, sc[7:0]) : s4.r;
            p5_reg  <= resc ? scale_corr(s4.p, sc[7:0]) : s4.p;
            y5_reg  <= resc ? scale_corr(s4.y, sc[7:0]) : s4.y;
        end
    end

    // stage 5: final mix and saturate into output register
    mix_t fm;
    assign fm = mix_f(cfg_reg.mode, t5_reg, r5_reg, p5_reg, y5_reg,
                      cfg_reg.servo_neutral);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid <= 1'b0;
        else if (adv) out_valid <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_cmd <= sat8(fm.m0);
            left_cmd  <= sat8(fm.m1);
            right_cmd <= sat8(fm.m2);
            back_cmd  <= sat8(fm.m3);
            rescaled  <= rs5_reg;
        end
    end

    // stalled output holds its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(front_cmd))
        else $error("stalled output changed");

    // rescale needs an upward swing
    a_resc_swing: assert property (@(posedge clk) disable iff (!rst_n)
        resc |-> s4.sp)
        else $error("rescale without swing");

    // in_ready is low only while a valid output is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("ready low without stall");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multirotor motor mixer: directed and random
// correction sets under varying frame settings, predicted in-bench and
// compared field by field with every output transfer.
// ----------------------------------------------------------------------------

// Expected output of one correction set
typedef struct {
    logic [7:0] front;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] back;
    logic       resc;
} mix_result_t;

class mixer_scoreboard;
    mmm_pkg::frame_t mode;
    int              out_max;
    int              low_run;
    int              neutral;
    mix_result_t     pending[$];
    int              errors;

    function new();
        mode    = mmm_pkg::FRAME_PLUS;
        out_max = 200;
        low_run = 20;
        neutral = 128;
        errors  = 0;
    endfunction

    static function int floor_half(int d);
        int h;
        if (d >= 0) h = d / 2;
        else h = -((-d + 1) / 2);
        return h;
    endfunction

    function void blend(int t, int r, int p, int y, output int m[4]);
        case (mode)
            mmm_pkg::FRAME_PLUS: begin
                m[0] = t - p + y; m[1] = t - r - y; m[2] = t + r - y; m[3] = t + p + y;
            end
            mmm_pkg::FRAME_CROSS: begin
                m[0] = t - p - r + y; m[1] = t + p - r - y;
                m[2] = t - p + r - y; m[3] = t + p + r + y;
            end
            mmm_pkg::FRAME_P45: begin
                m[0] = t + r - p + y; m[1] = t - r - p - y;
                m[2] = t + r + p - y; m[3] = t - r + p + y;
            end
            default: begin
                m[0] = t + p; m[1] = t + floor_half(r - p); m[2] = t - floor_half(r - p);
                m[3] = neutral + y;
            end
        endcase
    endfunction

    static function logic [7:0] clip8(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // Predict the commands for one accepted correction set
    function void note_input(logic [7:0] thr, logic signed [10:0] rc,
                             logic signed [10:0] pc, logic signed [10:0] yc);
        int t, r, p, y, lim, top, swing, hi, lo, s;
        int m[4];
        mix_result_t e;
        t = int'(thr); r = int'(rc); p = int'(pc); y = int'(yc);
        lim = (out_max * 90 + 50) / 100;
        if (t > lim) t = lim;
        e.resc = 1'b0;
        blend(t, r, p, y, m);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        if (mode != mmm_pkg::FRAME_TRI && m[3] > top) top = m[3];
        swing = top - t;
        if (swing > 0) begin
            hi = ((out_max - t) * 256) / swing;
            lo = ((t - low_run) * 256) / swing;
            s = hi < lo ? hi : lo;
            if (s < 0) s = 0;
            if (s < 256) begin
                e.resc = 1'b1;
                r = (r * s + 128) / 256;
                p = (p * s + 128) / 256;
                y = (y * s + 128) / 256;
                blend(t, r, p, y, m);
            end
        end
        e.front = clip8(m[0]); e.left = clip8(m[1]);
        e.right = clip8(m[2]); e.back = clip8(m[3]);
        pending.push_back(e);
    endfunction

    function void report(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endfunction

    function void check_output(logic [7:0] f, logic [7:0] l, logic [7:0] r,
                               logic [7:0] b, logic rs);
        mix_result_t e;
        if (pending.size() == 0) begin
            report("unexpected transfer, front", f, -1);
            return;
        end
        e = pending.pop_front();
        if (f !== e.front) report("front_cmd", f, e.front);
        if (l !== e.left) report("left_cmd", l, e.left);
        if (r !== e.right) report("right_cmd", r, e.right);
        if (b !== e.back) report("back_cmd", b, e.back);
        if (rs !== e.resc) report("rescaled", rs, e.resc);
    endfunction
endclass

module tb_top;
    import mmm_pkg::*;

    localparam int Latency = 22;
    localparam int StallLimit = 2000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = '0;
    logic [7:0]              cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [7:0]              throttle = '0;
    logic signed [CorrW-1:0] roll_corr = '0;
    logic signed [CorrW-1:0] pitch_corr = '0;
    logic signed [CorrW-1:0] yaw_corr = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [7:0]              front_cmd, left_cmd, right_cmd, back_cmd;
    logic                    rescaled;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    mixer_scoreboard sb = new();

    multirotor_motor_mixer uut (.*);

    always #10 clk = ~clk;

    // Monitor both handshakes and drive the receiver stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_input(throttle, roll_corr, pitch_corr, yaw_corr);
            if (out_valid && out_ready)
                sb.check_output(front_cmd, left_cmd, right_cmd, back_cmd, rescaled);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (quiet_cycles >= StallLimit) begin
            $display("multirotor_motor_mixer: mismatch");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_MODE: sb.mode = frame_t'(val[1:0]);
            REG_OUT_MAX: sb.out_max = int'(val);
            REG_LOW_RUN: sb.low_run = int'(val);
            default: sb.neutral = int'(val);
        endcase
    endtask

    task automatic set_frame(frame_t fm, int omax, int lrun, int neut);
        write_reg(REG_FRAME_MODE, 8'(fm));
        write_reg(REG_OUT_MAX, omax[7:0]);
        write_reg(REG_LOW_RUN, lrun[7:0]);
        write_reg(REG_SERVO_NEUTRAL, neut[7:0]);
    endtask

    // One input transfer; valid stays up across back-to-back items
    task automatic send_set(logic [7:0] t, logic [10:0] r, logic [10:0] p, logic [10:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        throttle <= t;
        roll_corr <= r;
        pitch_corr <= p;
        yaw_corr <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    // Mostly moderate corrections so that rescale paths get exercised
    task automatic send_random(int n);
        logic [10:0] r, p, y;
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                r = 11'($urandom); p = 11'($urandom); y = 11'($urandom);
            end else begin
                r = 11'($signed($urandom_range(160)) - 80);
                p = 11'($signed($urandom_range(160)) - 80);
                y = 11'($signed($urandom_range(80)) - 40);
            end
            send_set(8'($urandom), r, p, y);
        end
    endtask

    initial begin
        logic [10:0] ext[4];
        ext = '{11'h400, 11'h3FF, 11'h000, 11'h7FF};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, field extremes, no swing, low throttle
        send_set(8'd0, 11'd0, 11'd0, 11'd0);
        send_set(8'd255, 11'd0, 11'd0, 11'd0);
        send_set(8'd10, 11'd50, 11'd0, 11'd0);
        send_set(8'd255, 11'h400, 11'h3FF, 11'h400);
        send_set(8'd128, 11'h3FF, 11'h400, 11'h3FF);
        send_set(8'd100, 11'd20, 11'd10, 11'd5);
        drain();
        for (int fm = 0; fm < 4; fm++) begin
            set_frame(frame_t'(fm), (fm == 2) ? 255 : 200, 20, (fm == 3) ? 255 : 0);
            for (int k = 0; k < 4; k++)
                send_set(8'(k * 80 + 15), ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4]);
            drain();
        end

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 21; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                0: set_frame(FRAME_PLUS, 255, 0, 128);
                1: set_frame(FRAME_CROSS, 0, 255, 0);
                2: set_frame(FRAME_TRI, 200, 20, 255);
                3: set_frame(FRAME_P45, 180, 40, 60);
                default: set_frame(frame_t'($urandom_range(3)), $urandom_range(255),
                                   $urandom_range(80), $urandom_range(255));
            endcase
            send_random(55);
            // hold off until every result has come, then carry on
            in_valid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clk);
            send_random(55);
            drain();
        end

        if (sb.errors == 0)
            $display("multirotor_motor_mixer: match");
        else
            $display("multirotor_motor_mixer: mismatch");
        $finish;
    end
endmodule
